### rtl/core/frc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the FIFO-replacement key-value cache.
// No dependencies; used by frc_sweep and fifo_replacement_cache.
package frc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int OCC_W = 5;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // status of the sweep read pipeline, registered in the cycle after the address is issued
    typedef struct packed {
        logic vld;   // read data for p_idx is on the RAM outputs
        logic last;  // that entry is the final one of the sweep
    } sweep_stat_t;

endpackage

### rtl/core/frc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module frc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/frc_sweep.sv
`timescale 1ns / 1ps
// Address sequencer that walks every entry once, with a tag stage that
// tracks which entry the registered RAM read data belongs to. Uses frc_pkg.
module frc_sweep #(
    parameter int CAPACITY = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         start,
    output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
    output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] p_idx,
    output frc_pkg::sweep_stat_t                         stat
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             on_reg, on_next;
    logic             pvld_reg, pvld_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;

    always_comb begin
        addr_next = addr_reg;
        on_next   = on_reg;
        pvld_next = on_reg;
        pidx_next = addr_reg;
        if (on_reg) begin
            if (addr_reg == LAST_IDX) begin
                on_next = 1'b0;
            end else begin
                addr_next = addr_reg + IDX_W'(1);
            end
        end
        if (start) begin
            on_next   = 1'b1;
            addr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_reg   <= 1'b0;
            pvld_reg <= 1'b0;
            addr_reg <= '0;
        end else begin
            on_reg   <= on_next;
            pvld_reg <= pvld_next;
            addr_reg <= addr_next;
        end
        pidx_reg <= pidx_next;
    end

    assign rd_addr   = addr_reg;
    assign p_idx     = pidx_reg;
    assign stat.vld  = pvld_reg;
    assign stat.last = pvld_reg && (pidx_reg == LAST_IDX);

endmodule

### rtl/core/fifo_replacement_cache.sv
`timescale 1ns / 1ps
// Key-value cache with first-in-first-out replacement; top level.
// Uses frc_pkg, frc_sweep and frc_ram.
//
// One operation is in flight at a time. Key and age rank share one
// registered-read RAM, payloads sit in a second one; per-entry valid bits and
// the occupancy are flops. Every add, remove or lookup walks all CAPACITY
// entries through the key/rank RAM read port, one per cycle. A remove hit or
// an evicting add then walks the key/rank RAM a second time to close the gap
// in the age order (read-modify-write, one entry per cycle). Clear goes
// straight to the response without a walk. A stalled result adds its stall
// only when the next result is ready to go out. A new beat is taken while the
// previous result still waits on the output register. max_entries must be
// written only while idle; the block itself does not enforce it. 0 acts as 1
// and values above CAPACITY act as CAPACITY.
module fifo_replacement_cache #(
    parameter int CAPACITY = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic signed [frc_pkg::KEY_W-1:0]  s_key,
    input  logic [frc_pkg::VAL_W-1:0]         s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic [frc_pkg::VAL_W-1:0]         m_found_value,
    output logic                              m_evicted,
    output logic signed [frc_pkg::KEY_W-1:0]  m_evicted_key,
    output logic [frc_pkg::OCC_W-1:0]         m_occupancy,
    input  logic                              cfg_wr_en,
    input  logic [frc_pkg::CFG_W-1:0]         cfg_wr_data
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > frc_pkg::CFG_W) ? CNT_W : frc_pkg::CFG_W;
    localparam int KEY_W  = frc_pkg::KEY_W;
    localparam int VAL_W  = frc_pkg::VAL_W;
    localparam int ENT_W  = KEY_W + RANK_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_PICK   = 7'b0000100,
        ST_FETCH  = 7'b0001000,
        ST_DROP   = 7'b0010000,
        ST_INSERT = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    frc_pkg::kind_t              kind_reg, kind_next;
    logic [KEY_W-1:0]            key_reg, key_next;
    logic [VAL_W-1:0]            value_reg, value_next;
    logic [frc_pkg::CFG_W-1:0]   max_entries_reg;
    logic [CAPACITY-1:0]         valid_reg, valid_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    logic                        hit_reg, hit_next;
    logic [IDX_W-1:0]            hit_idx_reg, hit_idx_next;
    logic [RANK_W-1:0]           hit_rank_reg, hit_rank_next;
    logic                        old_found_reg, old_found_next;
    logic [IDX_W-1:0]            old_idx_reg, old_idx_next;
    logic [KEY_W-1:0]            old_key_reg, old_key_next;
    logic                        free_found_reg, free_found_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [RANK_W-1:0]           drop_rank_reg, drop_rank_next;

    logic                        ok_reg, ok_next;
    logic [VAL_W-1:0]            found_reg, found_next;
    logic                        ev_reg, ev_next;
    logic [KEY_W-1:0]            ev_key_reg, ev_key_next;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_ok_reg;
    logic [VAL_W-1:0]            m_found_reg;
    logic                        m_ev_reg;
    logic [KEY_W-1:0]            m_ev_key_reg;
    logic [frc_pkg::OCC_W-1:0]   m_occ_reg;
    logic                        out_load;

    // sweep and RAM wiring
    logic                        sweep_start;
    logic [IDX_W-1:0]            sweep_addr;
    logic [IDX_W-1:0]            p_idx;
    frc_pkg::sweep_stat_t        sweep_stat;
    logic [ENT_W-1:0]            ent_rd;
    logic [ENT_W-1:0]            ent_wr_data;
    logic [KEY_W-1:0]            key_rd;
    logic [VAL_W-1:0]            pay_rd;
    logic [RANK_W-1:0]           rank_rd;
    logic                        ins_we;
    logic [IDX_W-1:0]            ins_idx;
    logic                        drop_we;
    logic                        rank_we;
    logic [IDX_W-1:0]            rank_wr_addr;
    logic [RANK_W-1:0]           rank_wr_data;

    logic [CMP_W-1:0]            eff_max;
    logic                        p_valid;

    always_comb begin
        eff_max = CMP_W'(max_entries_reg);
        if (eff_max == '0) begin
            eff_max = CMP_W'(1);
        end else if (eff_max > CMP_W'(CAPACITY)) begin
            eff_max = CMP_W'(CAPACITY);
        end
    end

    assign p_valid = valid_reg[p_idx];

    // an evicting add prefers the lowest free slot, which may be the evicted one
    always_comb begin
        if (ev_reg && !(free_found_reg && (free_idx_reg < old_idx_reg))) begin
            ins_idx = old_idx_reg;
        end else begin
            ins_idx = free_idx_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_key_next    = old_key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        drop_rank_next  = drop_rank_reg;
        ok_next         = ok_reg;
        found_next      = found_reg;
        ev_next         = ev_reg;
        ev_key_next     = ev_key_reg;
        sweep_start     = 1'b0;
        ins_we          = 1'b0;
        drop_we         = 1'b0;
        out_load        = 1'b0;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next       = frc_pkg::kind_t'(s_kind);
                    key_next        = s_key;
                    value_next      = s_value;
                    hit_next        = 1'b0;
                    old_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    ok_next         = 1'b0;
                    found_next      = '0;
                    ev_next         = 1'b0;
                    ev_key_next     = '0;
                    if (frc_pkg::kind_t'(s_kind) == frc_pkg::KIND_CLEAR) begin
                        valid_next = '0;
                        count_next = '0;
                        ok_next    = 1'b1;
                        state_next = ST_RESP;
                    end else begin
                        sweep_start = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (sweep_stat.vld) begin
                    if (p_valid && (key_rd == key_reg) && !hit_reg) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = p_idx;
                        hit_rank_next = rank_rd;
                    end
                    if (p_valid && (rank_rd == '0)) begin
                        old_found_next = 1'b1;
                        old_idx_next   = p_idx;
                        old_key_next   = key_rd;
                    end
                    if (!p_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = p_idx;
                    end
                    if (sweep_stat.last) begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                unique case (kind_reg)
                    frc_pkg::KIND_ADD: begin
                        if (hit_reg) begin
                            state_next = ST_RESP;
                        end else if ((CMP_W'(count_reg) >= eff_max) && old_found_reg) begin
                            valid_next[old_idx_reg] = 1'b0;
                            count_next     = count_reg - CNT_W'(1);
                            drop_rank_next = '0;
                            ev_next        = 1'b1;
                            ev_key_next    = old_key_reg;
                            sweep_start    = 1'b1;
                            state_next     = ST_DROP;
                        end else begin
                            state_next = ST_INSERT;
                        end
                    end
                    frc_pkg::KIND_REMOVE: begin
                        if (hit_reg) begin
                            valid_next[hit_idx_reg] = 1'b0;
                            count_next     = count_reg - CNT_W'(1);
                            drop_rank_next = hit_rank_reg;
                            ok_next        = 1'b1;
                            sweep_start    = 1'b1;
                            state_next     = ST_DROP;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                    frc_pkg::KIND_LOOKUP: begin
                        if (hit_reg) begin
                            ok_next    = 1'b1;
                            state_next = ST_FETCH;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                    frc_pkg::KIND_CLEAR: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_FETCH: begin
                // payload RAM has been addressed at hit_idx since the scan ended
                found_next = pay_rd;
                state_next = ST_RESP;
            end
            ST_DROP: begin
                if (sweep_stat.vld) begin
                    if (p_valid && (rank_rd > drop_rank_reg)) begin
                        drop_we = 1'b1;
                    end
                    if (sweep_stat.last) begin
                        state_next = (kind_reg == frc_pkg::KIND_ADD) ? ST_INSERT : ST_RESP;
                    end
                end
            end
            ST_INSERT: begin
                if (ev_reg || free_found_reg) begin
                    ins_we              = 1'b1;
                    valid_next[ins_idx] = 1'b1;
                    count_next          = count_reg + CNT_W'(1);
                    ok_next             = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rank_we      = ins_we || drop_we;
    assign rank_wr_addr = ins_we ? ins_idx : p_idx;
    assign rank_wr_data = ins_we ? RANK_W'(count_reg) : (rank_rd - RANK_W'(1));
    // a rank update writes the key it just read back unchanged
    assign ent_wr_data  = {(ins_we ? key_reg : key_rd), rank_wr_data};

    assign key_rd  = ent_rd[ENT_W-1:RANK_W];
    assign rank_rd = ent_rd[RANK_W-1:0];

    assign m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            count_reg       <= '0;
            max_entries_reg <= frc_pkg::MAX_ENTRIES_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                max_entries_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_key_reg    <= old_key_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        drop_rank_reg  <= drop_rank_next;
        ok_reg         <= ok_next;
        found_reg      <= found_next;
        ev_reg         <= ev_next;
        ev_key_reg     <= ev_key_next;
        if (out_load) begin
            m_ok_reg     <= ok_reg;
            m_found_reg  <= found_reg;
            m_ev_reg     <= ev_reg;
            m_ev_key_reg <= ev_key_reg;
            m_occ_reg    <= frc_pkg::OCC_W'(count_reg);
        end
    end

    frc_sweep #(
        .CAPACITY (CAPACITY)
    ) u_sweep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sweep_start),
        .rd_addr (sweep_addr),
        .p_idx   (p_idx),
        .stat    (sweep_stat)
    );

    // key and age rank per entry
    frc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ent_ram (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (rank_wr_addr),
        .wr_data (ent_wr_data),
        .rd_addr (sweep_addr),
        .rd_data (ent_rd)
    );

    frc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_pay_ram (
        .aclk    (aclk),
        .wr_en   (ins_we),
        .wr_addr (ins_idx),
        .wr_data (value_reg),
        .rd_addr (hit_idx_reg),
        .rd_data (pay_rd)
    );

    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_found_value = m_found_reg;
    assign m_evicted     = m_ev_reg;
    assign m_evicted_key = m_ev_key_reg;
    assign m_occupancy   = m_occ_reg;

endmodule

### rtl/core/frc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for fifo_replacement_cache, attached by bind.
// Depends on the top level's port list only.
module frc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_ok,
    input logic [31:0] m_found_value,
    input logic        m_evicted,
    input logic [31:0] m_evicted_key
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_found_value)
            && $stable(m_evicted) && $stable(m_evicted_key))
        else $error("result beat changed while stalled");

    // one operation at a time: input closes right after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accepting a beat");

    // eviction only comes with a successful insert
    a_evict_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> m_ok)
        else $error("eviction without insert");

    a_evict_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted |-> m_evicted_key == 32'd0)
        else $error("evicted key nonzero without eviction");

    a_found_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_found_value != 32'd0) |-> m_ok && !m_evicted)
        else $error("payload returned without a lookup hit");

endmodule

bind fifo_replacement_cache frc_checker u_frc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ok          (m_ok),
    .m_found_value (m_found_value),
    .m_evicted     (m_evicted),
    .m_evicted_key (m_evicted_key)
);
